// ===== sv/binomial_coefficient_unit_defines.svh =====
// Assertion macros for the binomial coefficient unit
`ifndef BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BCU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define BCU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define BCU_ASSERT_IMP(lbl, ante, cons, msg)
`define BCU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bcu_pkg.sv =====
// Shared widths and types of the binomial coefficient unit
package bcu_pkg;

  localparam int NW  = 6;              // n, k, step and divisor width
  localparam int CW  = 64;             // coefficient width
  localparam int DCW = $clog2(CW);     // divider bit counter width

  typedef struct packed {
    logic          start;
    logic [CW-1:0] dividend;
    logic [NW-1:0] divisor;
  } div_req_t;

endpackage

// ===== sv/bcu_in_if.sv =====
// Request channel: operand pair (n, k)
interface bcu_in_if;
  logic                     valid;
  logic                     ready;
  logic [bcu_pkg::NW-1:0]   n_items;
  logic [bcu_pkg::NW-1:0]   k_choose;

  modport source (output valid, output n_items, output k_choose, input ready);
  modport sink   (input valid, input n_items, input k_choose, output ready);
endinterface

// ===== sv/bcu_out_if.sv =====
// Result channel: binomial coefficient
interface bcu_out_if;
  logic                     valid;
  logic                     ready;
  logic [bcu_pkg::CW-1:0]   coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

// ===== sv/bcu_divider.sv =====
// Restoring divider, one quotient bit per cycle, small divisor
`include "binomial_coefficient_unit_defines.svh"

module bcu_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bcu_pkg::div_req_t         req_i,
  output logic [bcu_pkg::CW-1:0]    quotient_o,
  output logic                      done_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [bcu_pkg::DCW-1:0]     cnt_q;
  logic [bcu_pkg::CW-1:0]      quot_q, quot_d;
  logic [bcu_pkg::NW-1:0]      rem_q, rem_d;
  logic [bcu_pkg::NW-1:0]      divisor_q;
  logic [bcu_pkg::NW:0]        rem_sh;
  logic                        ge;
  logic                        last;

  // shift in next dividend bit, subtract when it fits
  assign rem_sh = {rem_q, quot_q[bcu_pkg::CW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_q};
  assign rem_d  = ge ? bcu_pkg::NW'(rem_sh - {1'b0, divisor_q})
                     : rem_sh[bcu_pkg::NW-1:0];
  assign quot_d = {quot_q[bcu_pkg::CW-2:0], ge};
  assign last   = cnt_q == bcu_pkg::DCW'(bcu_pkg::CW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign quotient_o = quot_q;
  assign done_o     = done_q;

  `BCU_ASSERT_IMP(a_no_restart, req_i.start, !busy_q, "divider started while busy")
  `BCU_ASSERT_NXT(a_done_pulse, done_q, !done_q, "done held for more than one cycle")
  `BCU_ASSERT_IMP(a_rem_bound, busy_q, rem_q < divisor_q, "partial remainder not below divisor")

endmodule

// ===== sv/binomial_coefficient_unit.sv =====
// Top level of the binomial coefficient unit (multiplicative method)
//
//  channel  dir  payload                 handshake
//  req_i    in   n_items[5:0], k_choose  valid/ready, taken when both high
//  res_o    out  coefficient[63:0]       valid/ready, taken when both high
//
// Loop: s = min(k, n-k) passes, each a multiply state (MUL) and a wait
//   in DWAIT for the bit-serial divider, whose quotient is written back
//   to the accumulator before the next pass or DONE.
// k above n, k = 0 or k = n: no pass; the sequencer goes straight to DONE with a result of one.
// Reset: clears sequencer and result valid; no clearing pass.
// Stalls: a finished result waits in the output register; the next request
//   is taken meanwhile, and a later result waits in DONE until it is free.
`include "binomial_coefficient_unit_defines.svh"

module binomial_coefficient_unit #(
  parameter int MAX_N = 62
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bcu_in_if.sink   req_i,
  bcu_out_if.source res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DWAIT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [bcu_pkg::NW-1:0]      n_q, n_d;
  logic [bcu_pkg::NW-1:0]      step_q, step_d;
  logic [bcu_pkg::NW-1:0]      steps_q, steps_d;
  logic [bcu_pkg::CW-1:0]      acc_q, acc_d;
  logic                        out_valid_q;
  logic [bcu_pkg::CW-1:0]      out_data_q;

  logic                        in_acc;
  logic                        out_load;
  logic [bcu_pkg::NW-1:0]      n_sat, nk, steps_in, factor, step_inc;
  logic                        k_over;
  logic [bcu_pkg::CW-1:0]      product;

  bcu_pkg::div_req_t           div_req;
  logic [bcu_pkg::CW-1:0]      div_quot;
  logic                        div_done;

  // operand set-up: saturate n, fold k by symmetry
  assign n_sat    = (req_i.n_items > bcu_pkg::NW'(MAX_N)) ? bcu_pkg::NW'(MAX_N)
                                                          : req_i.n_items;
  assign k_over   = req_i.k_choose > n_sat;
  assign nk       = n_sat - req_i.k_choose;
  assign steps_in = (req_i.k_choose > nk) ? nk : req_i.k_choose;

  assign in_acc   = req_i.valid && req_i.ready;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  // 64 x 6 multiply; product of C(n,i) and (n-i) stays below 2^64 for n <= 62
  assign factor   = n_q - step_q;
  assign product  = acc_q * bcu_pkg::CW'(factor);
  assign step_inc = step_q + 1'b1;

  assign div_req.start    = state_q == ST_MUL;
  assign div_req.dividend = product;
  assign div_req.divisor  = step_inc;

  bcu_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    step_d  = step_q;
    steps_d = steps_q;
    acc_d   = acc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d     = n_sat;
          step_d  = '0;
          steps_d = steps_in;
          acc_d   = bcu_pkg::CW'(1);
          state_d = (k_over || (steps_in == '0)) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          acc_d   = div_quot;
          step_d  = step_inc;
          state_d = (step_inc == steps_q) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    step_q  <= step_d;
    steps_q <= steps_d;
    acc_q   <= acc_d;
    if (out_load) begin
      out_data_q <= acc_q;
    end
  end

  assign req_i.ready       = state_q == ST_IDLE;
  assign res_o.valid       = out_valid_q;
  assign res_o.coefficient = out_data_q;

  `BCU_ASSERT_IMP(a_step_bound, state_q == ST_DWAIT, step_q < steps_q, "step count overran")
  `BCU_ASSERT_IMP(a_done_in_wait, div_done, state_q == ST_DWAIT, "divider result unexpected")
  `BCU_ASSERT_NXT(a_k_over_one, in_acc && k_over, (state_q == ST_DONE) && (acc_q == bcu_pkg::CW'(1)), "k above n must give one")

endmodule

// ===== dv/testbench.sv =====
// Testbench of the binomial coefficient unit: directed and random requests checked by a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BCU_MAX_N     = 62;
  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int STALL_LIMIT   = 40000;  // cycles with no handshake on either channel
  localparam int DRAIN_CYCLES  = 2200;   // longest latency plus margin
  localparam int PHASE_ITEMS   = 89;

  typedef logic [bcu_pkg::NW-1:0] operand_t;
  typedef logic [bcu_pkg::CW-1:0] coeff_t;

  // Holds the coefficients still owed by the block, oldest first
  class coeff_scoreboard;
    coeff_t   expected_coeffs[$];
    operand_t req_n[$];
    operand_t req_k[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Multiplicative n choose k, n saturated to the block's maximum
    function void note_request(operand_t n, operand_t k);
      int unsigned nn;
      int unsigned steps;
      coeff_t      acc;
      nn  = 32'(n);
      acc = coeff_t'(1);
      if (nn > BCU_MAX_N) nn = BCU_MAX_N;
      if (k <= nn) begin
        steps = (k > nn - k) ? nn - k : k;
        for (int unsigned i = 0; i < steps; i++) begin
          acc = acc * coeff_t'(nn - i);
          acc = acc / coeff_t'(i + 1);
        end
      end
      expected_coeffs.push_back(acc);
      req_n.push_back(n);
      req_k.push_back(k);
    endfunction

    function void check_result(coeff_t actual);
      coeff_t   want;
      operand_t n;
      operand_t k;
      if (expected_coeffs.size() == 0) begin
        $error("coefficient: unexpected result %0d, no request outstanding", actual);
        errors++;
        return;
      end
      want = expected_coeffs.pop_front();
      n    = req_n.pop_front();
      k    = req_k.pop_front();
      if (actual !== want) begin
        $error("coefficient (n=%0d k=%0d): expected %0d, actual %0d", n, k, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_coeffs.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bcu_in_if  req_if ();
  bcu_out_if res_if ();

  binomial_coefficient_unit #(
    .MAX_N(BCU_MAX_N)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  coeff_scoreboard sb;
  int src_idle_pct;
  int snk_idle_pct;
  int quiet_cycles;

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.n_items = '0;
    req_if.k_choose = '0;
    res_if.ready   = 1'b0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    quiet_cycles   = 0;
    sb             = new();
  end

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Result side back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) sb.check_result(res_if.coefficient);
      if ((res_if.valid && res_if.ready) || (req_if.valid && req_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_request(operand_t n, operand_t k);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.n_items  <= n;
    req_if.k_choose <= k;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(n, k);
    @(negedge clk_i);
  endtask

  // Mostly small n; a few at full size to exercise the long loop
  task automatic send_random_requests(int count);
    int       sel;
    operand_t n;
    operand_t k;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 68) begin
        n = operand_t'($urandom_range(20));
        k = operand_t'($urandom_range(n + 1));
      end else if (sel < 84) begin
        n = operand_t'($urandom);
        k = operand_t'($urandom);
      end else if (sel < 95) begin
        // trivial cases: k zero, k equal to n, k above n
        n = operand_t'($urandom);
        case ($urandom_range(2))
          0: k = '0;
          1: k = n;
          default: k = operand_t'($urandom_range(63, (n >= 62) ? 63 : n + 1));
        endcase
      end else begin
        n = operand_t'($urandom_range(63, 60));
        k = operand_t'($urandom_range(42, 20));
      end
      drive_request(n, k);
    end
  endtask

  initial begin
    operand_t dir_n[$];
    operand_t dir_k[$];
    dir_n = '{0, 0, 1, 1, 1, 62, 62, 62, 62, 62, 63, 63, 63, 63, 62, 5, 10, 10, 10, 61,
              0, 20, 42, 63};
    dir_k = '{0, 1, 0, 1, 2, 31, 0, 62, 1, 61, 31, 63, 62, 0, 63, 10, 5, 3, 7, 30,
              63, 10, 21, 32};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase 1: sender idles a third of the time, receiver mostly stalls
    src_idle_pct = 33;
    snk_idle_pct = 87;
    foreach (dir_n[i]) drive_request(dir_n[i], dir_k[i]);
    send_random_requests(PHASE_ITEMS);

    // Phase 2: roles swapped
    src_idle_pct = 87;
    snk_idle_pct = 33;
    send_random_requests(PHASE_ITEMS);

    // Phase 3: full rate both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random_requests(PHASE_ITEMS);
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
